// ----- hdl/fen3d_pkg.sv -----
package fen3d_pkg;

    localparam int MAX_SIDE = 32;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int ADDR_W   = 3 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int SUM_W    = 64;
    localparam int AMT_W    = 32;
    localparam int CFG_W    = 6;

    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [SIDE_W-1:0] walk_t;

endpackage

// ----- hdl/fenwick_3d_box_sum_core.sv -----
// Add transaction: a read state and an update state per tree cell touched, up to 6^3 cells at side 32.
// Query transaction: a read and an update state per cell over eight prefix walks, up to
// 8 * 5^3 cells at side 32; the shared 64-bit adder and one RAM read port serve each cell.
// One transaction in flight; the next is taken while a finished result still waits.
// After rst_n the cell store is cleared one word a cycle, all 32768 words, with in_stall high.
// The size register resets to 32 and accepts writes at any time (cfg_ready is always high).
module fenwick_3d_box_sum_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fen3d_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [fen3d_pkg::COORD_W-1:0]     corner_x,
    input  logic [fen3d_pkg::COORD_W-1:0]     corner_y,
    input  logic [fen3d_pkg::COORD_W-1:0]     corner_z,
    input  logic [fen3d_pkg::COORD_W-1:0]     far_x,
    input  logic [fen3d_pkg::COORD_W-1:0]     far_y,
    input  logic [fen3d_pkg::COORD_W-1:0]     far_z,
    input  logic signed [fen3d_pkg::AMT_W-1:0] amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fen3d_pkg::SUM_W-1:0] box_sum
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CORNER = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam int CW = fen3d_pkg::COORD_W;
    localparam int SW = fen3d_pkg::SIDE_W;
    localparam int AW = fen3d_pkg::ADDR_W;
    localparam logic [SW-1:0] SIDE_MAX = SW'(fen3d_pkg::MAX_SIDE);

    logic [2:0]                   state_reg, state_next;
    logic [fen3d_pkg::CFG_W-1:0]  size_reg, size_next;
    logic [AW-1:0]                clr_reg, clr_next;
    logic                         op_add_reg, op_add_next;
    logic [CW-1:0]                lx_reg, ly_reg, lz_reg, lx_next, ly_next, lz_next;
    logic [CW-1:0]                hx_reg, hy_reg, hz_reg, hx_next, hy_next, hz_next;
    fen3d_pkg::sum_t              amt_reg, amt_next;
    fen3d_pkg::sum_t              acc_reg, acc_next;
    logic [2:0]                   corner_reg, corner_next;
    fen3d_pkg::walk_t             a_reg, b_reg, c_reg, a_next, b_next, c_next;
    fen3d_pkg::walk_t             sb_reg, sc_reg, sb_next, sc_next;
    logic                         out_valid_reg, out_valid_next;
    fen3d_pkg::sum_t              box_sum_reg, box_sum_next;

    logic [SW-1:0]     side;
    logic [CW-1:0]     side_m1;
    logic              add_skip;
    logic              q_skip;
    logic [CW-1:0]     qx, qy, qz;
    logic              neg;
    fen3d_pkg::sum_t   op_a, op_b, adder_out;
    logic              cin;
    logic [AW-1:0]     cell_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    fen3d_pkg::sum_t   ram_wdata;
    fen3d_pkg::sum_t   ram_rdata;
    fen3d_pkg::walk_t  a_step, b_step, c_step;
    logic              a_end, b_end, c_end;

    // Fenwick index step: climb towards the side on an add, descend on a query
    function automatic logic [SW:0] walk_step(input logic [SW-1:0] v, input logic up,
                                              input logic [SW-1:0] lim);
        logic [SW-1:0] inc;
        logic [SW-1:0] nxt;
        logic          fin;
        inc = SW'(v + SW'(1));
        if (up)
        begin
            nxt = v | inc;
            fin = (nxt >= lim);
        end
        else
        begin
            nxt = SW'((v & inc) - SW'(1));
            fin = ((v & inc) == '0);
        end
        return {fin, nxt};
    endfunction

    function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v, input logic [CW-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    assign side    = ({1'b0, size_reg} > {1'b0, SIDE_MAX}) ? SIDE_MAX : SW'(size_reg);
    assign side_m1 = CW'(side - SW'(1));

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign box_sum   = box_sum_reg;

    assign add_skip = (side == '0) || ({1'b0, corner_x} >= side) ||
                      ({1'b0, corner_y} >= side) || ({1'b0, corner_z} >= side);

    // Corner bit set selects the low side minus one; a low of zero there gives nothing
    assign q_skip = (side == '0) ||
                    (corner_reg[0] && lx_reg == '0) ||
                    (corner_reg[1] && ly_reg == '0) ||
                    (corner_reg[2] && lz_reg == '0);
    assign qx  = clamp(corner_reg[0] ? CW'(lx_reg - CW'(1)) : hx_reg, side_m1);
    assign qy  = clamp(corner_reg[1] ? CW'(ly_reg - CW'(1)) : hy_reg, side_m1);
    assign qz  = clamp(corner_reg[2] ? CW'(lz_reg - CW'(1)) : hz_reg, side_m1);
    assign neg = ^corner_reg;

    // Shared adder: read-modify-write on adds, signed accumulate on queries
    assign op_a      = op_add_reg ? ram_rdata : acc_reg;
    assign op_b      = op_add_reg ? amt_reg : (neg ? ~ram_rdata : ram_rdata);
    assign cin       = !op_add_reg && neg;
    assign adder_out = op_a + op_b + fen3d_pkg::SUM_W'(cin);

    assign cell_addr = {a_reg[CW-1:0], b_reg[CW-1:0], c_reg[CW-1:0]};
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_UPD && op_add_reg);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : cell_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : adder_out;

    assign {a_end, a_step} = walk_step(a_reg, op_add_reg, side);
    assign {b_end, b_step} = walk_step(b_reg, op_add_reg, side);
    assign {c_end, c_step} = walk_step(c_reg, op_add_reg, side);

    fen3d_ram #(
        .WIDTH (fen3d_pkg::SUM_W),
        .DEPTH (fen3d_pkg::DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        clr_next       = clr_reg;
        op_add_next    = op_add_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        lz_next        = lz_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        hz_next        = hz_reg;
        amt_next       = amt_reg;
        acc_next       = acc_reg;
        corner_next    = corner_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        sb_next        = sb_reg;
        sc_next        = sc_reg;
        out_valid_next = out_valid_reg;
        box_sum_next   = box_sum_reg;

        if (cfg_valid)
        begin
            size_next = cfg_data;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = AW'(clr_reg + AW'(1));
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_add_next = !action;
                    lx_next     = corner_x;
                    ly_next     = corner_y;
                    lz_next     = corner_z;
                    hx_next     = far_x;
                    hy_next     = far_y;
                    hz_next     = far_z;
                    amt_next    = fen3d_pkg::SUM_W'(amount);
                    acc_next    = '0;
                    corner_next = '0;
                    a_next      = SW'(corner_x);
                    b_next      = SW'(corner_y);
                    c_next      = SW'(corner_z);
                    sb_next     = SW'(corner_y);
                    sc_next     = SW'(corner_z);
                    if (action)
                    begin
                        state_next = ST_CORNER;
                    end
                    else if (!add_skip)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_CORNER:
            begin
                if (q_skip)
                begin
                    corner_next = 3'(corner_reg + 3'd1);
                    if (corner_reg == '1)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    a_next     = SW'(qx);
                    b_next     = SW'(qy);
                    c_next     = SW'(qz);
                    sb_next    = SW'(qy);
                    sc_next    = SW'(qz);
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!op_add_reg)
                begin
                    acc_next = adder_out;
                end
                state_next = ST_RD;
                if (!c_end)
                begin
                    c_next = c_step;
                end
                else if (!b_end)
                begin
                    c_next = sc_reg;
                    b_next = b_step;
                end
                else if (!a_end)
                begin
                    c_next = sc_reg;
                    b_next = sb_reg;
                    a_next = a_step;
                end
                else if (op_add_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Walk finished: move to the next corner or hand over the sum
                    corner_next = 3'(corner_reg + 3'd1);
                    state_next  = (corner_reg == '1) ? ST_DONE : ST_CORNER;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    box_sum_next   = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            size_reg      <= fen3d_pkg::CFG_W'(fen3d_pkg::MAX_SIDE);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_add_reg  <= op_add_next;
        lx_reg      <= lx_next;
        ly_reg      <= ly_next;
        lz_reg      <= lz_next;
        hx_reg      <= hx_next;
        hy_reg      <= hy_next;
        hz_reg      <= hz_next;
        amt_reg     <= amt_next;
        acc_reg     <= acc_next;
        corner_reg  <= corner_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        sb_reg      <= sb_next;
        sc_reg      <= sc_next;
        box_sum_reg <= box_sum_next;
    end

endmodule

// ----- hdl/fen3d_ram.sv -----
module fen3d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
